@@ hdl/lfr_pkg.sv @@
// Shared types and constants for the layer fade ramp engine.
// Depends on nothing; every other file in hdl/ imports it.
`timescale 1ns / 1ps

package lfr_pkg;

  localparam int LEVEL_W = 6;
  localparam int DIV_W   = 16;
  localparam int STEP_W  = 4;
  localparam int MASK_W  = 8;
  localparam int LEVELS_W = 48;

  // operation codes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;
  localparam logic [1:0] OP_SET   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_MAX_LEVEL = 2'd0;
  localparam logic [1:0] CFG_TICK_DIV  = 2'd1;
  localparam logic [1:0] CFG_UPDATE_HZ = 2'd2;

  localparam logic [5:0] MAX_LEVEL_RST = 6'd16;
  localparam logic [5:0] TICK_DIV_RST  = 6'd1;
  localparam logic [9:0] UPDATE_HZ_RST = 10'd60;

  // stages of the start rate division chain
  localparam logic [1:0] STG_HZ     = 2'd0;  // update_rate_hz / tick_divider
  localparam logic [1:0] STG_PERIOD = 2'd1;  // 1000 / previous
  localparam logic [1:0] STG_STEPS  = 2'd2;  // fade_ms / previous
  localparam logic [1:0] STG_RATE   = 2'd3;  // max_level / previous

  localparam logic [DIV_W-1:0]   MS_PER_SEC = 16'd1000;
  localparam logic [STEP_W-1:0]  DIV_LAST   = 4'd15;
  localparam logic [LEVEL_W-1:0] RATE_CLIP  = 6'd63;

  typedef struct packed {
    logic [1:0]  operation;
    logic        screen;
    logic [1:0]  layer;
    logic        fade_in;
    logic [15:0] fade_ms;
    logic        notify;
    logic [5:0]  level;
  } in_item_t;

  typedef struct packed {
    logic [7:0]          fired_mask;
    logic [7:0]          active_mask;
    logic [7:0]          direction_mask;
    logic [LEVELS_W-1:0] levels;
  } out_item_t;

  typedef struct packed {
    logic [5:0] max_level;
    logic [5:0] tick_divider;
    logic [9:0] update_rate_hz;
  } cfg_t;

  typedef struct packed {
    logic       capture;
    logic       clear;
    logic       set_level;
    logic       prescale;
    logic       div_load;
    logic       div_step;
    logic [1:0] div_stage;
    logic       commit;
    logic       sat;
    logic       walk;
    logic       publish;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       id_ok;
    logic       tick_acts;
    logic       div_zero;
  } dp_stat_t;

endpackage

@@ hdl/lfr_divider.sv @@
// Restoring divider, one quotient bit per step, for the start rate chain.
// Depends on lfr_pkg.
`timescale 1ns / 1ps

module lfr_divider (
  input  logic                      clk,
  input  logic                      load,
  input  logic                      step,
  input  logic [lfr_pkg::DIV_W-1:0] dividend,
  input  logic [lfr_pkg::DIV_W-1:0] divisor,
  output logic [lfr_pkg::DIV_W-1:0] quotient
);
  import lfr_pkg::*;

  logic [DIV_W-1:0] quo_r;
  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] dsr_r;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;

  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign diff  = trial - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (load) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (step) begin
      if (!diff[DIV_W]) begin
        rem_r <= diff[DIV_W-1:0];
        quo_r <= {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[DIV_W-1:0];
        quo_r <= {quo_r[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = quo_r;

endmodule

@@ hdl/lfr_datapath.sv @@
// Layer state, prescaler, rate divider and the per-layer step unit.
// Depends on lfr_pkg and lfr_divider; driven by lfr_ctrl commands.
`timescale 1ns / 1ps

module lfr_datapath #(
  parameter int LAYERS = 8,
  parameter int IDXW   = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lfr_pkg::cfg_t        cfg,
  input  lfr_pkg::in_item_t    in_data,
  input  lfr_pkg::ctl_cmd_t    cmd,
  input  logic [IDXW-1:0]      walk_idx,
  output lfr_pkg::dp_stat_t    stat,
  output lfr_pkg::out_item_t   result
);
  import lfr_pkg::*;

  localparam logic [3:0] LAYERS4 = 4'(LAYERS);

  in_item_t          item_r;
  logic [LEVEL_W-1:0] level_r [LAYERS];
  logic [LEVEL_W-1:0] rate_r  [LAYERS];
  logic [LAYERS-1:0] en_r;
  logic [LAYERS-1:0] dir_r;
  logic [LAYERS-1:0] ntf_r;
  logic [LAYERS-1:0] fired_r;
  logic [5:0]        pre_r;

  logic [2:0]        id;
  logic [IDXW-1:0]   id_idx;
  logic              id_ok;
  logic [5:0]        tdiv;
  logic [5:0]        pre_inc;
  logic              tick_acts;

  logic [DIV_W-1:0]  dvd;
  logic [DIV_W-1:0]  dsr;
  logic [DIV_W-1:0]  quo;
  logic [LEVEL_W-1:0] new_rate;

  logic [LEVEL_W-1:0] w_lvl;
  logic [6:0]        w_step;
  logic [6:0]        w_sum;
  logic [LEVEL_W-1:0] w_up;
  logic [LEVEL_W-1:0] w_down;
  logic              w_end;

  assign id      = {item_r.screen, item_r.layer};
  assign id_idx  = id[IDXW-1:0];
  assign id_ok   = ({1'b0, id} < LAYERS4);

  // prescaler: a zero divider behaves as one
  assign tdiv      = (cfg.tick_divider == '0) ? 6'd1 : cfg.tick_divider;
  assign pre_inc   = pre_r + 6'd1;
  assign tick_acts = (pre_inc == '0) || (pre_inc >= tdiv);

  // operand select for the division chain
  always_comb begin
    case (cmd.div_stage)
      STG_HZ: begin
        dvd = {6'd0, cfg.update_rate_hz};
        dsr = {10'd0, cfg.tick_divider};
      end
      STG_PERIOD: begin
        dvd = MS_PER_SEC;
        dsr = quo;
      end
      STG_STEPS: begin
        dvd = item_r.fade_ms;
        dsr = quo;
      end
      default: begin
        dvd = {10'd0, cfg.max_level};
        dsr = quo;
      end
    endcase
  end

  lfr_divider u_div (
    .clk      (clk),
    .load     (cmd.div_load),
    .step     (cmd.div_step),
    .dividend (dvd),
    .divisor  (dsr),
    .quotient (quo)
  );

  always_comb begin
    if (cmd.sat) new_rate = cfg.max_level;
    else if (quo > {10'd0, RATE_CLIP}) new_rate = RATE_CLIP;
    else new_rate = quo[LEVEL_W-1:0];
  end

  // one layer step toward its end, clamped there
  assign w_lvl  = level_r[walk_idx];
  assign w_step = {1'b0, rate_r[walk_idx]} + 7'd1;
  assign w_sum  = {1'b0, w_lvl} + w_step;
  assign w_up   = (w_sum >= {1'b0, cfg.max_level}) ? cfg.max_level : w_sum[LEVEL_W-1:0];
  assign w_down = ({1'b0, w_lvl} <= w_step) ? '0 : (w_lvl - w_step[LEVEL_W-1:0]);
  assign w_end  = dir_r[walk_idx] ? (w_lvl == cfg.max_level) : (w_lvl == '0);

  always_ff @(posedge clk) begin
    if (cmd.capture) item_r <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAYERS; i++) begin
        level_r[i] <= '0;
        rate_r[i]  <= '0;
      end
      en_r    <= '0;
      dir_r   <= '0;
      ntf_r   <= '0;
      fired_r <= '0;
      pre_r   <= '0;
    end else begin
      if (cmd.capture) fired_r <= '0;
      if (cmd.clear) begin
        for (int i = 0; i < LAYERS; i++) begin
          level_r[i] <= '0;
          rate_r[i]  <= '0;
        end
        en_r  <= '0;
        dir_r <= '0;
        ntf_r <= '0;
      end
      if (cmd.set_level && id_ok) level_r[id_idx] <= item_r.level;
      if (cmd.prescale) pre_r <= tick_acts ? 6'd0 : pre_inc;
      if (cmd.commit) begin
        en_r[id_idx]   <= 1'b1;
        dir_r[id_idx]  <= item_r.fade_in;
        ntf_r[id_idx]  <= item_r.notify;
        rate_r[id_idx] <= new_rate;
      end
      if (cmd.walk && en_r[walk_idx]) begin
        if (w_end) begin
          en_r[walk_idx]    <= 1'b0;
          fired_r[walk_idx] <= ntf_r[walk_idx];
          ntf_r[walk_idx]   <= 1'b0;
        end else begin
          level_r[walk_idx] <= dir_r[walk_idx] ? w_up : w_down;
        end
      end
    end
  end

  always_comb begin
    result = '0;
    result.fired_mask     = MASK_W'(fired_r);
    result.active_mask    = MASK_W'(en_r);
    result.direction_mask = MASK_W'(dir_r);
    for (int i = 0; i < LAYERS; i++) begin
      result.levels[LEVEL_W*i +: LEVEL_W] = level_r[i];
    end
  end

  assign stat.op        = item_r.operation;
  assign stat.id_ok     = id_ok;
  assign stat.tick_acts = tick_acts;
  assign stat.div_zero  = (dsr == '0);

endmodule

@@ hdl/lfr_ctrl.sv @@
// Sequencer for the fade engine: dispatch, division chain, layer walk, publish.
// Depends on lfr_pkg; commands lfr_datapath.
`timescale 1ns / 1ps

module lfr_ctrl #(
  parameter int LAYERS = 8,
  parameter int IDXW   = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 out_free,
  input  lfr_pkg::dp_stat_t    stat,
  output lfr_pkg::ctl_cmd_t    cmd,
  output logic [IDXW-1:0]      walk_idx
);
  import lfr_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DISP   = 3'd1;
  localparam logic [2:0] S_LOAD   = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;
  localparam logic [2:0] S_WALK   = 3'd5;
  localparam logic [2:0] S_PUB    = 3'd6;

  localparam logic [IDXW-1:0] WALK_LAST = IDXW'(LAYERS - 1);

  logic [2:0]        state_r, state_nxt;
  logic [1:0]        stage_r, stage_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [IDXW-1:0]   widx_r, widx_nxt;

  always_comb begin
    state_nxt = state_r;
    stage_nxt = stage_r;
    step_nxt  = step_r;
    widx_nxt  = widx_r;
    cmd       = '0;
    cmd.div_stage = stage_r;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_PUB;
        case (stat.op)
          OP_CLEAR: cmd.clear = 1'b1;
          OP_SET:   cmd.set_level = 1'b1;
          OP_TICK: begin
            cmd.prescale = 1'b1;
            widx_nxt     = '0;
            if (stat.tick_acts) state_nxt = S_WALK;
          end
          OP_START: begin
            stage_nxt = STG_HZ;
            if (stat.id_ok) state_nxt = S_LOAD;
          end
          default: state_nxt = S_PUB;
        endcase
      end
      S_LOAD: begin
        // a zero divisor anywhere in the chain saturates the rate
        if (stat.div_zero) begin
          cmd.commit = 1'b1;
          cmd.sat    = 1'b1;
          state_nxt  = S_PUB;
        end else begin
          cmd.div_load = 1'b1;
          step_nxt     = '0;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == DIV_LAST) begin
          if (stage_r == STG_RATE) begin
            state_nxt = S_COMMIT;
          end else begin
            stage_nxt = stage_r + 2'd1;
            state_nxt = S_LOAD;
          end
        end else begin
          step_nxt = step_r + 4'd1;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_PUB;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (widx_r == WALK_LAST) state_nxt = S_PUB;
        else widx_nxt = widx_r + 1'b1;
      end
      S_PUB: begin
        if (out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      stage_r <= STG_HZ;
      step_r  <= '0;
      widx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      stage_r <= stage_nxt;
      step_r  <= step_nxt;
      widx_r  <= widx_nxt;
    end
  end

  assign walk_idx = widx_r;

endmodule

@@ hdl/layer_fade_ramp_engine_top.sv @@
// Top level of the layer fade ramp engine: handshakes, config and result register.
// Depends on lfr_pkg, lfr_ctrl, lfr_datapath and lfr_divider.
`timescale 1ns / 1ps

// Fade engine for up to eight display layers (id = screen * 4 + layer). Every
// input beat yields exactly one result beat carrying the fired, active and
// direction masks and the packed levels after the operation. Items are handled
// one at a time by a sequencer. A tick that acts walks the min(LAYER_COUNT, 8)
// layers one by one through the shared step unit; a start runs the four chained
// divisions of the rate computation, each producing a 16-bit quotient on one
// bit-serial divider (a zero divisor ends the chain early). The result sits in
// an output register, so the next input beat is taken while a result still
// waits on out_ready. Configuration beats are always accepted and must only
// come while the engine is idle; index 3 is ignored. No clearing pass follows
// reset.
module layer_fade_ramp_engine_top #(
  parameter int LAYER_COUNT = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lfr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output lfr_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [9:0]         cfg_data
);
  import lfr_pkg::*;

  // layers that an id can reach and that show on the outputs
  localparam int LAYERS = (LAYER_COUNT < 8) ? LAYER_COUNT : 8;
  localparam int IDXW   = $clog2(LAYERS);

  cfg_t       cfg_r;
  out_item_t  out_data_r;
  logic       out_valid_r;
  logic       out_free;
  ctl_cmd_t   cmd;
  dp_stat_t   stat;
  out_item_t  result;
  logic [IDXW-1:0] walk_idx;

  // configuration registers; the host must write them only while idle (not enforced here)
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_level      <= MAX_LEVEL_RST;
      cfg_r.tick_divider   <= TICK_DIV_RST;
      cfg_r.update_rate_hz <= UPDATE_HZ_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MAX_LEVEL: cfg_r.max_level      <= cfg_data[5:0];
        CFG_TICK_DIV:  cfg_r.tick_divider   <= cfg_data[5:0];
        CFG_UPDATE_HZ: cfg_r.update_rate_hz <= cfg_data;
        default: ;
      endcase
    end
  end

  // the result register is free when empty or draining this cycle
  assign out_free = !out_valid_r || out_ready;

  lfr_ctrl #(
    .LAYERS (LAYERS),
    .IDXW   (IDXW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_free (out_free),
    .stat     (stat),
    .cmd      (cmd),
    .walk_idx (walk_idx)
  );

  lfr_datapath #(
    .LAYERS (LAYERS),
    .IDXW   (IDXW)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_data  (in_data),
    .cmd      (cmd),
    .walk_idx (walk_idx),
    .stat     (stat),
    .result   (result)
  );

  // hold the result beat until taken; load a new one on publish
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) out_data_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
